// File: hw/rtl/lmec_pkg.sv
// Shared types and constants for the local map edge contrast block.
`timescale 1ns / 1ps

package lmec_pkg;

  localparam int ROW_W   = 8;
  localparam int COL_W   = 8;
  localparam int PIX_W   = 16;
  localparam int EDGE_W  = 20;
  localparam int DIM_W   = 9;
  localparam int ACC_W   = 22;
  localparam int TAP_W   = 4;
  localparam logic [TAP_W-1:0] LAST_TAP = 4'd8;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic [1:0] {
    W_CENTRE = 2'd0,
    W_CROSS  = 2'd1,
    W_DIAG   = 2'd2
  } weight_t;

  typedef struct packed {
    logic    clear;
    logic    add;
    weight_t weight;
  } acc_ctl_t;

endpackage

// File: hw/rtl/lmec_store.sv
// Single-ported pixel frame store with registered read data.
`timescale 1ns / 1ps

module lmec_store
  import lmec_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hw/rtl/lmec_acc.sv
// Weighted accumulator that sums the nine taps of one read.
`timescale 1ns / 1ps

module lmec_acc
  import lmec_pkg::*;
(
  input  logic              clk,
  input  acc_ctl_t          ctl,
  input  logic [PIX_W-1:0]  data,
  output logic [EDGE_W-1:0] edge_out
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] d_ext;

  assign d_ext = $signed({{(ACC_W-PIX_W){1'b0}}, data});

  // Centre counts twelve times, cross taps minus two, diagonals minus one.
  always_comb begin
    case (ctl.weight)
      W_CENTRE: term = (d_ext <<< 3) + (d_ext <<< 2);
      W_CROSS:  term = -(d_ext <<< 1);
      W_DIAG:   term = -d_ext;
      default:  term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + term;
    end
  end

  assign edge_out = acc[ACC_W-1] ? '0 : acc[EDGE_W-1:0];

endmodule

// File: hw/rtl/local_map_edge_contrast.sv
// Top level: request decode, tap sequencer, frame store and accumulator.
// A write leaves busy low, and the next item may follow at once.
// A read inside the frame makes nine store reads on the single port in FETCH,
// folds in the last tap in DRAIN, and ends in a RESULT state in which a new item may start.
// A read outside the frame gives its result in the cycle after it is taken.
// done marks each result for one cycle. Synchronous reset sets the frame to 256 by 256.
`timescale 1ns / 1ps

module local_map_edge_contrast
  import lmec_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int REACH      = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [ROW_W-1:0]  pixel_row,
  input  logic [COL_W-1:0]  pixel_col,
  input  logic [PIX_W-1:0]  pixel_value,
  output logic              done,
  output logic [EDGE_W-1:0] edge_value,
  output logic              bad_position
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    FETCH  = 4'b0010,
    DRAIN  = 4'b0100,
    RESULT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] frame_width, frame_height;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [DIM_W-1:0] row_in, col_in;
  logic [DIM_W-1:0] rm_in, rp_in, cm_in, cp_in;
  logic [DIM_W-1:0] row, col, rm, rp, cm, cp;
  logic [DIM_W-1:0] tap_row, tap_col;
  logic [TAP_W-1:0] tap_cnt;
  logic             in_frame, accept, accept_rd;
  logic             fetch_q;
  weight_t          tap_weight, weight_q;
  acc_ctl_t         acc_ctl;
  logic             store_we;
  logic [AW-1:0]    store_addr;
  logic [PIX_W-1:0] store_rdata;
  logic [EDGE_W-1:0] acc_edge;

  // Frame size saturates to the store's dimensions.
  assign eff_w = (32'(frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width;
  assign eff_h = (32'(frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height;

  assign row_in   = {1'b0, pixel_row};
  assign col_in   = {1'b0, pixel_col};
  assign in_frame = (row_in < eff_h) && (col_in < eff_w);

  assign rm_in = (row_in >= DIM_W'(REACH)) ? row_in - DIM_W'(REACH) : '0;
  assign cm_in = (col_in >= DIM_W'(REACH)) ? col_in - DIM_W'(REACH) : '0;
  assign rp_in = (row_in + DIM_W'(REACH) > eff_h - 1'b1) ? eff_h - 1'b1
                                                        : row_in + DIM_W'(REACH);
  assign cp_in = (col_in + DIM_W'(REACH) > eff_w - 1'b1) ? eff_w - 1'b1
                                                        : col_in + DIM_W'(REACH);

  assign busy      = (state == FETCH) || (state == DRAIN);
  assign accept    = start && !busy;
  assign accept_rd = accept && (req_type == REQ_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      IDLE, RESULT: begin
        state_next = IDLE;
        if (accept_rd) begin
          state_next = in_frame ? FETCH : RESULT;
        end
      end
      FETCH:   state_next = (tap_cnt == LAST_TAP) ? DRAIN : FETCH;
      DRAIN:   state_next = RESULT;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      tap_cnt <= '0;
      fetch_q <= 1'b0;
    end else begin
      state   <= state_next;
      fetch_q <= (state == FETCH);
      if (state == FETCH) begin
        tap_cnt <= tap_cnt + 1'b1;
      end else begin
        tap_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    weight_q <= tap_weight;
    if (accept_rd) begin
      row          <= row_in;
      col          <= col_in;
      rm           <= rm_in;
      rp           <= rp_in;
      cm           <= cm_in;
      cp           <= cp_in;
      bad_position <= !in_frame;
    end
  end

  // Tap order: centre, four cross neighbours, then the four diagonals.
  always_comb begin
    case (tap_cnt)
      4'd0:    begin tap_row = row; tap_col = col; end
      4'd1:    begin tap_row = row; tap_col = cm;  end
      4'd2:    begin tap_row = row; tap_col = cp;  end
      4'd3:    begin tap_row = rm;  tap_col = col; end
      4'd4:    begin tap_row = rp;  tap_col = col; end
      4'd5:    begin tap_row = rm;  tap_col = cm;  end
      4'd6:    begin tap_row = rm;  tap_col = cp;  end
      4'd7:    begin tap_row = rp;  tap_col = cm;  end
      default: begin tap_row = rp;  tap_col = cp;  end
    endcase
    if (tap_cnt == '0) begin
      tap_weight = W_CENTRE;
    end else if (tap_cnt inside {[4'd1:4'd4]}) begin
      tap_weight = W_CROSS;
    end else begin
      tap_weight = W_DIAG;
    end
  end

  assign store_we = accept && (req_type == REQ_WRITE) && in_frame;

  always_comb begin
    if (busy) begin
      store_addr = AW'(32'(tap_row) * MAX_WIDTH) + AW'(tap_col);
    end else begin
      store_addr = AW'(32'(row_in) * MAX_WIDTH) + AW'(col_in);
    end
  end

  lmec_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .addr  (store_addr),
    .wdata (pixel_value),
    .rdata (store_rdata)
  );

  assign acc_ctl.clear  = accept_rd;
  assign acc_ctl.add    = fetch_q;
  assign acc_ctl.weight = weight_q;

  lmec_acc u_acc (
    .clk      (clk),
    .ctl      (acc_ctl),
    .data     (store_rdata),
    .edge_out (acc_edge)
  );

  assign done       = (state == RESULT);
  assign edge_value = bad_position ? '0 : acc_edge;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a read is still fetching");

  a_drain_to_result: assert property (@(posedge clk) disable iff (rst)
    (state == DRAIN) |=> done)
    else $error("drain cycle not followed by a result");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    store_we |-> !busy)
    else $error("store written during a tap fetch");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == FETCH) |-> (tap_cnt <= LAST_TAP))
    else $error("tap counter past the last tap");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_position) |-> (edge_value == '0))
    else $error("out-of-frame read returned a nonzero value");

endmodule
